// ===== rtl/wtach_pkg.sv =====
package wtach_pkg;

  // Default build parameters
  localparam int COUNT_WIDTH_DEF   = 15;
  localparam int FRACTION_BITS_DEF = 4;

  // Fixed field widths
  localparam int EDGE_W  = 8;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int HZ_W    = 29;
  localparam int RPM_W   = 35;
  localparam int PULSE_W = 15;
  localparam int DEN_W   = 32;  // ticks * pulses_per_rev

  // Scale factors: Hz per pulse-per-ms, and rpm per pulse-per-ms
  localparam int HZ_SCALE    = 1000;
  localparam int HZ_SCALE_W  = 10;
  localparam int RPM_SCALE   = 60000;
  localparam int RPM_SCALE_W = 16;

  localparam logic [HZ_W-1:0]  HZ_MAX  = '1;
  localparam logic [RPM_W-1:0] RPM_MAX = '1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSES_REV = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] WINDOW_MS_RST  = 16'd500;
  localparam logic [CFG_W-1:0] PULSES_REV_RST = 16'd1;
  localparam logic [CFG_W-1:0] TIMEOUT_MS_RST = 16'd1000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PREP,
    ST_DIV_HZ_GO,
    ST_DIV_HZ,
    ST_SMOOTH_HZ,
    ST_DIV_RPM_GO,
    ST_DIV_RPM,
    ST_SMOOTH_RPM,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic tick;        // request accepted: advance window counters
    logic prep;        // form numerators and rpm divisor
    logic div_start;   // launch the shared divider
    logic div_sel;     // 0: frequency division, 1: rpm division
    logic smooth_hz;
    logic smooth_rpm;
    logic finish;      // timeout check, load result, clear window
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic close;       // window has reached its length
    logic div_busy;
    logic out_hold;    // result register still occupied next cycle
  } dp_status_t;

endpackage

// ===== rtl/wtach_div.sv =====
module wtach_div #(
  parameter int DW = wtach_pkg::COUNT_WIDTH_DEF + wtach_pkg::RPM_SCALE_W
                     + wtach_pkg::FRACTION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DW-1:0]              dividend,
  input  logic [wtach_pkg::DEN_W-1:0] divisor,
  output logic                       busy,
  output logic [DW-1:0]              quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]               dq;      // dividend bits out, quotient bits in
  logic [wtach_pkg::DEN_W-1:0] rem;
  logic [wtach_pkg::DEN_W-1:0] den;
  logic [CNT_W-1:0]            cnt;

  logic [wtach_pkg::DEN_W:0]   shifted;
  logic [wtach_pkg::DEN_W:0]   diff;
  logic                        ge;

  // One restoring step: bring down the next dividend bit
  always_comb begin
    shifted = {rem, dq[DW-1]};
    ge      = shifted >= {1'b0, den};
    diff    = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      dq  <= {dq[DW-2:0], ge};
      rem <= ge ? diff[wtach_pkg::DEN_W-1:0] : shifted[wtach_pkg::DEN_W-1:0];
    end
  end

  assign quotient = dq;

endmodule

// ===== rtl/wtach_dp.sv =====
module wtach_dp #(
  parameter int COUNT_WIDTH   = wtach_pkg::COUNT_WIDTH_DEF,
  parameter int FRACTION_BITS = wtach_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [wtach_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wtach_pkg::CFG_W-1:0]       cfg_data,
  input  logic [wtach_pkg::EDGE_W-1:0]      edges,
  input  wtach_pkg::ctrl_cmd_t              cmd,
  output wtach_pkg::dp_status_t             status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [wtach_pkg::HZ_W-1:0]        hz_avg_out,
  output logic [wtach_pkg::RPM_W-1:0]       rpm_avg_out,
  output logic [wtach_pkg::PULSE_W-1:0]     window_pulses_out,
  output logic                              stalled
);

  localparam int HZ_W  = wtach_pkg::HZ_W;
  localparam int RPM_W = wtach_pkg::RPM_W;
  localparam int CFG_W = wtach_pkg::CFG_W;
  localparam int DEN_W = wtach_pkg::DEN_W;
  localparam int DW    = COUNT_WIDTH + wtach_pkg::RPM_SCALE_W + FRACTION_BITS;
  localparam int QX    = DW + RPM_W;
  localparam int HP_W  = COUNT_WIDTH + wtach_pkg::HZ_SCALE_W;
  localparam int RP_W  = COUNT_WIDTH + wtach_pkg::RPM_SCALE_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Configuration registers
  logic [CFG_W-1:0] window_ms;
  logic [CFG_W-1:0] pulses_per_rev;
  logic [CFG_W-1:0] timeout_ms;

  // Window and smoothing state
  logic [CFG_W-1:0]       window_ticks;
  logic [COUNT_WIDTH-1:0] window_count;
  logic [CFG_W-1:0]       ms_since_pulse;
  logic                   pulse_ever_seen;
  logic [HZ_W-1:0]        hz_average;
  logic [RPM_W-1:0]       rpm_average;

  // Division operands
  logic [DW-1:0]    num_hz;
  logic [DW-1:0]    num_rpm;
  logic [DEN_W-1:0] den_rpm;

  logic [COUNT_WIDTH:0]   count_sum;
  logic [COUNT_WIDTH-1:0] count_sat;
  logic [CFG_W-1:0]       ticks_eff;
  logic [CFG_W-1:0]       ppr_eff;
  logic [HP_W-1:0]        hz_prod;
  logic [RP_W-1:0]        rpm_prod;
  logic [DEN_W-1:0]       den_prod;
  logic [DW-1:0]          div_dividend;
  logic [DEN_W-1:0]       div_divisor;
  logic                   div_busy;
  logic [DW-1:0]          quotient;
  logic [QX-1:0]          q_ext;
  logic [HZ_W-1:0]        hz_sat;
  logic [RPM_W-1:0]       rpm_sat;
  logic [HZ_W+1:0]        hz_mix;
  logic [RPM_W+1:0]       rpm_mix;
  logic [HZ_W-1:0]        hz_smooth;
  logic [RPM_W-1:0]       rpm_smooth;
  logic                   stall_now;

  // Config write port; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms      <= wtach_pkg::WINDOW_MS_RST;
      pulses_per_rev <= wtach_pkg::PULSES_REV_RST;
      timeout_ms     <= wtach_pkg::TIMEOUT_MS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        wtach_pkg::REG_WINDOW_MS:  window_ms      <= cfg_data;
        wtach_pkg::REG_PULSES_REV: pulses_per_rev <= cfg_data;
        wtach_pkg::REG_TIMEOUT_MS: timeout_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturating window count add
  always_comb begin
    count_sum = {1'b0, window_count} + (COUNT_WIDTH + 1)'(edges);
    count_sat = count_sum[COUNT_WIDTH] ? COUNT_MAX : count_sum[COUNT_WIDTH-1:0];
  end

  // Window counters and pulse timeout tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks    <= '0;
      window_count    <= '0;
      ms_since_pulse  <= '0;
      pulse_ever_seen <= 1'b0;
    end else if (cmd.tick) begin
      window_ticks <= window_ticks + 1'b1;
      window_count <= count_sat;
      if (ms_since_pulse != '1) begin
        ms_since_pulse <= ms_since_pulse + 1'b1;
      end
    end else if (cmd.prep) begin
      if (window_count != '0) begin
        ms_since_pulse  <= '0;
        pulse_ever_seen <= 1'b1;
      end
    end else if (cmd.finish) begin
      window_ticks <= '0;
      window_count <= '0;
    end
  end

  // Numerators and rpm divisor, registered ahead of the divider
  always_comb begin
    ticks_eff = (window_ticks == '0) ? CFG_W'(1) : window_ticks;
    ppr_eff   = (pulses_per_rev == '0) ? CFG_W'(1) : pulses_per_rev;
    hz_prod   = HP_W'(window_count) * HP_W'(wtach_pkg::HZ_SCALE);
    rpm_prod  = RP_W'(window_count) * RP_W'(wtach_pkg::RPM_SCALE);
    den_prod  = DEN_W'(ticks_eff) * DEN_W'(ppr_eff);
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      num_hz  <= DW'(hz_prod) << FRACTION_BITS;
      num_rpm <= DW'(rpm_prod) << FRACTION_BITS;
      den_rpm <= den_prod;
    end
  end

  // Shared serial divider
  assign div_dividend = cmd.div_sel ? num_rpm : num_hz;
  assign div_divisor  = cmd.div_sel ? den_rpm : DEN_W'(ticks_eff);

  wtach_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Saturate quotient, then average with weight 1/4
  always_comb begin
    q_ext   = QX'(quotient);
    hz_sat  = (q_ext > QX'(wtach_pkg::HZ_MAX)) ? wtach_pkg::HZ_MAX : q_ext[HZ_W-1:0];
    rpm_sat = (q_ext > QX'(wtach_pkg::RPM_MAX)) ? wtach_pkg::RPM_MAX : q_ext[RPM_W-1:0];
    hz_mix  = {2'b00, hz_average} + {1'b0, hz_average, 1'b0} + {2'b00, hz_sat};
    rpm_mix = {2'b00, rpm_average} + {1'b0, rpm_average, 1'b0} + {2'b00, rpm_sat};
    hz_smooth  = (hz_average == '0) ? hz_sat : hz_mix[HZ_W+1:2];
    rpm_smooth = (rpm_average == '0) ? rpm_sat : rpm_mix[RPM_W+1:2];
    stall_now  = pulse_ever_seen && (ms_since_pulse > timeout_ms);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hz_average  <= '0;
      rpm_average <= '0;
    end else if (cmd.smooth_hz) begin
      hz_average <= hz_smooth;
    end else if (cmd.smooth_rpm) begin
      rpm_average <= rpm_smooth;
    end else if (cmd.finish && stall_now) begin
      hz_average  <= '0;
      rpm_average <= '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hz_avg_out        <= stall_now ? '0 : hz_average;
      rpm_avg_out       <= stall_now ? '0 : rpm_average;
      window_pulses_out <= wtach_pkg::PULSE_W'(window_count);
      stalled           <= stall_now;
    end
  end

  assign status.close    = window_ticks >= window_ms;
  assign status.div_busy = div_busy;
  assign status.out_hold = out_valid && !out_ready;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(out_valid && !out_ready))
    else $error("result register overwritten");

  a_stall_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stalled) |-> (hz_avg_out == '0 && rpm_avg_out == '0))
    else $error("stalled result with nonzero averages");

  a_window_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (window_ticks == '0 && window_count == '0))
    else $error("window not cleared after result");
`endif

endmodule

// ===== rtl/wtach_ctrl.sv =====
module wtach_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  wtach_pkg::dp_status_t status,
  output wtach_pkg::ctrl_cmd_t  cmd
);

  wtach_pkg::state_t state;
  wtach_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wtach_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      wtach_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.tick   = 1'b1;
          state_next = wtach_pkg::ST_CHECK;
        end
      end
      wtach_pkg::ST_CHECK: begin
        state_next = status.close ? wtach_pkg::ST_PREP : wtach_pkg::ST_IDLE;
      end
      wtach_pkg::ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = wtach_pkg::ST_DIV_HZ_GO;
      end
      wtach_pkg::ST_DIV_HZ_GO: begin
        cmd.div_start = 1'b1;
        state_next    = wtach_pkg::ST_DIV_HZ;
      end
      wtach_pkg::ST_DIV_HZ: begin
        if (!status.div_busy) begin
          state_next = wtach_pkg::ST_SMOOTH_HZ;
        end
      end
      wtach_pkg::ST_SMOOTH_HZ: begin
        cmd.smooth_hz = 1'b1;
        state_next    = wtach_pkg::ST_DIV_RPM_GO;
      end
      wtach_pkg::ST_DIV_RPM_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_next    = wtach_pkg::ST_DIV_RPM;
      end
      wtach_pkg::ST_DIV_RPM: begin
        if (!status.div_busy) begin
          state_next = wtach_pkg::ST_SMOOTH_RPM;
        end
      end
      wtach_pkg::ST_SMOOTH_RPM: begin
        cmd.smooth_rpm = 1'b1;
        state_next     = wtach_pkg::ST_FINISH;
      end
      wtach_pkg::ST_FINISH: begin
        // wait for the result register to free up
        if (!status.out_hold) begin
          cmd.finish = 1'b1;
          state_next = wtach_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wtach_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/windowed_tachometer_ema.sv =====
// Windowed tachometer with exponential smoothing.
// Input channel (in_valid/in_ready, edges): one request per millisecond tick,
// carrying the qualified edges seen in that tick. Ticks accumulate into a
// window; when the window length is reached one result goes out on the
// output channel (out_valid/out_ready): smoothed Hz and rpm (4 fraction
// bits by default), the window's pulse count and a stall flag.
// Config port (cfg_we, cfg_index, cfg_data): window_ms, pulses_per_rev,
// timeout_ms; write only while no tick is in progress.
// Timing: a tick that does not close the window goes from idle through a
// window check back to idle. A closing tick runs two divisions on one serial
// restoring divider, one quotient bit per cycle over DW = COUNT_WIDTH +
// FRACTION_BITS + 16 bits; out_valid rises in the same cycle that in_ready
// returns, so the next tick can be accepted as soon as the result is out.
// The result sits in an output register, so ticks keep flowing while it
// waits; if the receiver still holds the previous result when the next one
// is ready, the block waits before loading it and takes no new tick.
// Reset (rst, synchronous) restores register defaults, clears the window,
// averages and timeout state, and drops out_valid.
module windowed_tachometer_ema #(
  parameter int COUNT_WIDTH   = wtach_pkg::COUNT_WIDTH_DEF,
  parameter int FRACTION_BITS = wtach_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [wtach_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wtach_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [wtach_pkg::EDGE_W-1:0]    edges,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [wtach_pkg::HZ_W-1:0]      hz_avg_out,
  output logic [wtach_pkg::RPM_W-1:0]     rpm_avg_out,
  output logic [wtach_pkg::PULSE_W-1:0]   window_pulses_out,
  output logic                            stalled
);

  wtach_pkg::ctrl_cmd_t  cmd;
  wtach_pkg::dp_status_t status;

  wtach_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wtach_dp #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .edges             (edges),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .hz_avg_out        (hz_avg_out),
    .rpm_avg_out       (rpm_avg_out),
    .window_pulses_out (window_pulses_out),
    .stalled           (stalled)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int EDGE_W          = wtach_pkg::EDGE_W;
  localparam int CFG_W           = wtach_pkg::CFG_W;
  localparam int CFG_IDX_W       = wtach_pkg::CFG_IDX_W;
  localparam int HZ_W            = wtach_pkg::HZ_W;
  localparam int RPM_W           = wtach_pkg::RPM_W;
  localparam int PULSE_W         = wtach_pkg::PULSE_W;
  localparam int COUNT_WIDTH_DEF = wtach_pkg::COUNT_WIDTH_DEF;
  localparam int FRACTION_BITS_DEF = wtach_pkg::FRACTION_BITS_DEF;

  localparam int DIV_BITS      = COUNT_WIDTH_DEF + FRACTION_BITS_DEF + 16;
  localparam int SETTLE_CYCLES = 2 * DIV_BITS + 30;
  localparam int RX_HOLD_CYCLES = 1000;
  localparam int COUNT_SAT     = (1 << COUNT_WIDTH_DEF) - 1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // One closed window as seen on the result channel
  typedef struct packed {
    logic [HZ_W-1:0]    hz;
    logic [RPM_W-1:0]   rpm;
    logic [PULSE_W-1:0] pulses;
    logic               stall;
  } speed_report_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [EDGE_W-1:0]    edges = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [HZ_W-1:0]      hz_avg_out;
  logic [RPM_W-1:0]     rpm_avg_out;
  logic [PULSE_W-1:0]   window_pulses_out;
  logic                 stalled;

  // Expected window reports, oldest first
  speed_report_t report_q[$];

  // Shadow registers and tachometer state
  logic [CFG_W-1:0]           reg_window  = wtach_pkg::WINDOW_MS_RST;
  logic [CFG_W-1:0]           reg_ppr     = wtach_pkg::PULSES_REV_RST;
  logic [CFG_W-1:0]           reg_timeout = wtach_pkg::TIMEOUT_MS_RST;
  logic [15:0]                win_ticks   = '0;
  logic [COUNT_WIDTH_DEF-1:0] win_count   = '0;
  logic [15:0]                quiet_ms    = '0;
  logic                       pulse_seen  = 1'b0;
  logic [63:0]                hz_ema      = '0;
  logic [63:0]                rpm_ema     = '0;

  bit          idle_en = 1'b1;
  bit          rx_hold_req = 1'b0;
  int          rx_hold_left = 0;
  int          rx_idle_left = 0;
  int unsigned err_count = 0;
  int unsigned ticks_sent = 0;
  int unsigned reports_checked = 0;
  int unsigned stalls_checked = 0;

  windowed_tachometer_ema u_top (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .edges             (edges),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .hz_avg_out        (hz_avg_out),
    .rpm_avg_out       (rpm_avg_out),
    .window_pulses_out (window_pulses_out),
    .stalled           (stalled)
  );

  always #4 clk = ~clk;

  // Run limit
  initial begin
    #8_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // Quarter-weight smoothing; an empty average takes the new value
  function automatic logic [63:0] ema_quarter(input logic [63:0] avg,
                                              input logic [63:0] raw);
    return (avg == '0) ? raw : ((64'd3 * avg + raw) >> 2);
  endfunction

  // Advance the tachometer by one millisecond tick
  function automatic void predict_tick(input logic [EDGE_W-1:0] e);
    logic [63:0]   sum;
    logic [63:0]   span;
    logic [63:0]   ppr;
    logic [63:0]   scaled;
    logic [63:0]   raw_hz;
    logic [63:0]   raw_rpm;
    speed_report_t r;
    win_ticks = win_ticks + 16'd1;
    sum = 64'(win_count) + 64'(e);
    win_count = (sum > 64'(COUNT_SAT)) ? COUNT_WIDTH_DEF'(COUNT_SAT) : COUNT_WIDTH_DEF'(sum);
    if (quiet_ms != 16'hFFFF) quiet_ms = quiet_ms + 16'd1;
    if (win_ticks < reg_window) return;

    // window closes: wrapped tick count and zero ppr both divide by one
    span = (win_ticks == '0) ? 64'd1 : 64'(win_ticks);
    ppr = (reg_ppr == '0) ? 64'd1 : 64'(reg_ppr);
    scaled = (64'(win_count) * 64'd1000) << FRACTION_BITS_DEF;
    raw_hz = scaled / span;
    if (raw_hz > 64'(wtach_pkg::HZ_MAX)) raw_hz = 64'(wtach_pkg::HZ_MAX);
    raw_rpm = (scaled * 64'd60) / (span * ppr);
    if (raw_rpm > 64'(wtach_pkg::RPM_MAX)) raw_rpm = 64'(wtach_pkg::RPM_MAX);

    if (win_count != '0) begin
      quiet_ms = '0;
      pulse_seen = 1'b1;
    end
    hz_ema = ema_quarter(hz_ema, raw_hz);
    rpm_ema = ema_quarter(rpm_ema, raw_rpm);
    r.stall = 1'b0;
    if (pulse_seen && quiet_ms > reg_timeout) begin
      hz_ema = '0;
      rpm_ema = '0;
      r.stall = 1'b1;
    end
    r.hz = hz_ema[HZ_W-1:0];
    r.rpm = rpm_ema[RPM_W-1:0];
    r.pulses = PULSE_W'(win_count);
    report_q.push_back(r);
    win_ticks = '0;
    win_count = '0;
  endfunction

  // Send one tick request; called and returns at a falling edge
  task automatic send_tick(input logic [EDGE_W-1:0] e);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1'b1;
    edges <= e;
    do @(posedge clk); while (!in_ready);
    predict_tick(e);
    ticks_sent++;
    @(negedge clk);
  endtask

  // Drop valid, wait for every report, then let a last tick finish
  task automatic settle();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      wtach_pkg::REG_WINDOW_MS:  reg_window = val;
      wtach_pkg::REG_PULSES_REV: reg_ppr = val;
      wtach_pkg::REG_TIMEOUT_MS: reg_timeout = val;
      default: ;
    endcase
  endtask

  task automatic apply_setup(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] p,
                             input logic [CFG_W-1:0] t);
    settle();
    write_reg(wtach_pkg::REG_WINDOW_MS, w);
    write_reg(wtach_pkg::REG_PULSES_REV, p);
    write_reg(wtach_pkg::REG_TIMEOUT_MS, t);
  endtask

  // Register defaults: one 500 ms window; full-scale ticks up front
  // drive the window count into its clip
  task automatic test_reset_values();
    repeat (130) send_tick('1);
    repeat (370) send_tick(EDGE_W'($urandom_range(0, 3)));
  endtask

  task automatic test_directed_cases();
    // one-tick windows, short timeout: empty window before any pulse,
    // full-scale edges, then a quiet run that stalls and a restart from zero
    apply_setup(16'd1, 16'd1, 16'd2);
    send_tick(8'd0);
    send_tick(8'd255);
    send_tick(8'd1);
    send_tick(8'd128);
    send_tick(8'd255);
    send_tick(8'd0);
    send_tick(8'd0);
    send_tick(8'd0);
    send_tick(8'd0);
    send_tick(8'd7);
    // zero window closes every tick, zero ppr acts as one,
    // zero timeout stalls any empty window
    apply_setup(16'd0, 16'd0, 16'd0);
    send_tick(8'd0);
    send_tick(8'd3);
    send_tick(8'd200);
    // unused register index is ignored
    settle();
    write_reg(REG_UNUSED, 16'hFFFF);
    send_tick(8'd9);
    send_tick(8'd0);
    // largest ppr and timeout
    apply_setup(16'd3, 16'hFFFF, 16'hFFFF);
    send_tick(8'd255);
    send_tick(8'd255);
    send_tick(8'd255);
    send_tick(8'd1);
    send_tick(8'd2);
    send_tick(8'd3);
  endtask

  // Receiver holds off while ticks keep coming, so the block backs up
  task automatic test_output_backpressure();
    apply_setup(16'd1, 16'd3, 16'hFFFF);
    @(posedge clk);
    rx_hold_req = 1'b1;
    @(negedge clk);
    repeat (30) send_tick(EDGE_W'($urandom_range(0, 255)));
  endtask

  // Sender stops until every report is back, then resumes
  task automatic test_sender_pause();
    apply_setup(16'd2, 16'd1, 16'd5);
    repeat (10) send_tick(EDGE_W'($urandom_range(0, 255)));
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    repeat (10) send_tick(EDGE_W'($urandom_range(0, 255)));
  endtask

  task automatic test_random_windows(input int phases, input int per_phase);
    int               sent;
    int               run;
    int               kind;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] p;
    logic [CFG_W-1:0] t;
    for (int ph = 0; ph < phases; ph++) begin
      case ($urandom_range(0, 3))
        0: w = CFG_W'($urandom_range(0, 3));
        1, 2: w = CFG_W'($urandom_range(1, 12));
        default: w = CFG_W'($urandom_range(13, 60));
      endcase
      case ($urandom_range(0, 3))
        0: p = '0;
        1: p = '1;
        2: p = CFG_W'($urandom_range(1, 8));
        default: p = CFG_W'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: t = '0;
        1: t = CFG_W'($urandom_range(1, 40));
        2: t = '1;
        default: t = CFG_W'($urandom);
      endcase
      apply_setup(w, p, t);
      sent = 0;
      // runs of silence (timeouts), random traffic, full scale, trickle
      while (sent < per_phase) begin
        kind = $urandom_range(0, 3);
        run = (kind == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
        repeat (run) begin
          case (kind)
            0: send_tick('0);
            1: send_tick(EDGE_W'($urandom_range(0, 255)));
            2: send_tick('1);
            default: send_tick(EDGE_W'($urandom_range(0, 3)));
          endcase
          sent++;
        end
      end
    end
  endtask

  // Receiver ready: long hold on request, else random idle bursts
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else if (rx_idle_left > 0) begin
      rx_idle_left--;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      rx_idle_left = $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted report with the oldest expectation
  always @(posedge clk) begin : report_check
    speed_report_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (report_q.size() == 0) begin
        $error("unexpected report: hz_avg_out %0d rpm_avg_out %0d", hz_avg_out, rpm_avg_out);
        err_count++;
      end else begin
        exp_r = report_q.pop_front();
        if (hz_avg_out !== exp_r.hz) begin
          $error("hz_avg_out: expected %0d, actual %0d", exp_r.hz, hz_avg_out);
          err_count++;
        end
        if (rpm_avg_out !== exp_r.rpm) begin
          $error("rpm_avg_out: expected %0d, actual %0d", exp_r.rpm, rpm_avg_out);
          err_count++;
        end
        if (window_pulses_out !== exp_r.pulses) begin
          $error("window_pulses_out: expected %0d, actual %0d", exp_r.pulses,
                 window_pulses_out);
          err_count++;
        end
        if (stalled !== exp_r.stall) begin
          $error("stalled: expected %0d, actual %0d", exp_r.stall, stalled);
          err_count++;
        end
        reports_checked++;
        if (exp_r.stall) stalls_checked++;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_directed_cases();
    test_output_backpressure();
    test_sender_pause();
    test_random_windows(2, 16);
    idle_en = 1'b0;
    test_random_windows(1, 16);
    settle();
    $display("tb_top summary: %0d ticks sent, %0d window reports checked, %0d of them stalled",
             ticks_sent, reports_checked, stalls_checked);
    $display("tb_top summary: default window with clipped count, zero and full-scale registers");
    if (err_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
